FILE: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the first-fit region allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

  localparam int DATA_W      = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEMORY_SIZE  = 1'b1;

  localparam logic [DATA_W-1:0] RESET_REGION_START = 32'h0010_0000;
  localparam logic [DATA_W-1:0] RESET_MEMORY_SIZE  = 32'h0100_0000;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  // operand source of the page remainder unit
  typedef enum logic {
    REM_SRC_START = 1'b0,
    REM_SRC_UPPER = 1'b1
  } rem_src_t;

  typedef struct packed {
    logic     req_take;
    logic     scan_clear;
    logic     scan_run;
    logic     find_clear;
    logic     find_run;
    logic     rem_start;
    rem_src_t rem_src;
    logic     wr_rebuild;
    logic     wr_low;
    logic     wr_up;
    logic     wr_hit;
    logic     rsp_load;
    status_t  rsp_code;
  } ffra_cmd_t;

  typedef struct packed {
    logic cfg_write;
    logic rem_done;
    logic scan_done;
    logic scan_hit;
    logic need_ok;
    logic find_done;
    logic low_split;
    logic rsp_free;
  } ffra_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ffra_if.sv
// ----------------------------------------------------------------------------
// ffra_req_if / ffra_rsp_if
// Valid/ready channels for allocation requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] request_length;

  modport source (output valid, output opcode, output request_length, input ready);
  modport sink   (input valid, input opcode, input request_length, output ready);
endinterface

interface ffra_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] granted_address;

  modport source (output valid, output status, output granted_address, input ready);
  modport sink   (input valid, input status, input granted_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over a table of memory regions, with split of the
// remainder and optional page alignment of the grant.
//
// Requests come in on req (opcode: plain or page-aligned, request_length),
// accepted when req.valid and req.ready are high at a clock edge. Each gives
// one result on rsp (status, granted_address) unless a register write cuts in.
// Per request: a first-fit scan of one table entry per cycle, a search for
// empty entries at one entry per cycle, the page offset of the upper split
// and the writes of the lower split (if any), the upper split and the hit
// entry. A scan with no fit gives no space; too few empty entries give table
// full. PAGE_BYTES must be a power of two.
// The result sits in an output register; req.ready rises again once the
// result is loaded, so the next request is taken while rsp stalls.
// A register write (write_enable, register_index, write_data) rebuilds the
// table as one free region; after reset or a write, the rebuild runs through
// S_RB_START and S_RB_WAIT, during which no request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator #(
  parameter int TABLE_ENTRIES = 64,
  parameter int PAGE_BYTES    = 4096
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              write_enable,
  input  wire [ffra_pkg::CFG_INDEX_W-1:0]  register_index,
  input  wire [31:0]                       write_data,
  ffra_req_if.sink                         req,
  ffra_rsp_if.source                       rsp
);

  ffra_pkg::ffra_cmd_t  cmd;
  ffra_pkg::ffra_stat_t stat;
  logic                 in_ready;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [31:0]          out_address;

  assign req.ready           = in_ready;
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.granted_address = out_address;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffra_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PAGE_BYTES    (PAGE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .in_opcode      (req.opcode),
    .in_length      (req.request_length),
    .out_valid      (out_valid),
    .out_ready      (rsp.ready),
    .out_status     (out_status),
    .out_address    (out_address),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

`default_nettype wire

FILE: rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: table rebuild, first-fit scan, empty-entry search, split writes.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ffra_pkg::ffra_stat_t stat,
  output ffra_pkg::ffra_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_RB_START  = 11'b000_0000_0001,
    S_RB_WAIT   = 11'b000_0000_0010,
    S_IDLE      = 11'b000_0000_0100,
    S_SCAN      = 11'b000_0000_1000,
    S_CHECK     = 11'b000_0001_0000,
    S_FIND      = 11'b000_0010_0000,
    S_LOW       = 11'b000_0100_0000,
    S_REM_START = 11'b000_1000_0000,
    S_REM_WAIT  = 11'b001_0000_0000,
    S_UP        = 11'b010_0000_0000,
    S_HIT       = 11'b100_0000_0000
  } state_t;

  // result waiting for the output register shares the idle code space
  state_t            state, state_next;
  logic              done_pend, done_pend_next;
  ffra_pkg::status_t code, code_next;

  assign in_ready = (state == S_IDLE) && !done_pend;

  always_comb begin
    state_next     = state;
    code_next      = code;
    done_pend_next = done_pend;
    cmd            = '0;
    cmd.rem_src    = ffra_pkg::REM_SRC_START;
    cmd.rsp_code   = code;
    if (done_pend) begin
      if (stat.rsp_free) begin
        cmd.rsp_load   = 1'b1;
        done_pend_next = 1'b0;
      end
    end else begin
      unique case (state)
        S_RB_START: begin
          cmd.rem_start = 1'b1;
          cmd.rem_src   = ffra_pkg::REM_SRC_START;
          state_next    = S_RB_WAIT;
        end
        S_RB_WAIT: begin
          if (stat.rem_done) begin
            cmd.wr_rebuild = 1'b1;
            state_next     = S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd.req_take   = 1'b1;
            cmd.scan_clear = 1'b1;
            state_next     = S_SCAN;
          end
        end
        S_SCAN: begin
          cmd.scan_run = 1'b1;
          if (stat.scan_done) begin
            if (stat.scan_hit) begin
              state_next = S_CHECK;
            end else begin
              code_next      = ffra_pkg::ST_NO_SPACE;
              done_pend_next = 1'b1;
              state_next     = S_IDLE;
            end
          end
        end
        S_CHECK: begin
          if (stat.need_ok) begin
            cmd.find_clear = 1'b1;
            state_next     = S_FIND;
          end else begin
            code_next      = ffra_pkg::ST_TABLE_FULL;
            done_pend_next = 1'b1;
            state_next     = S_IDLE;
          end
        end
        S_FIND: begin
          cmd.find_run = 1'b1;
          if (stat.find_done) begin
            state_next = stat.low_split ? S_LOW : S_REM_START;
          end
        end
        S_LOW: begin
          cmd.wr_low = 1'b1;
          state_next = S_REM_START;
        end
        S_REM_START: begin
          cmd.rem_start = 1'b1;
          cmd.rem_src   = ffra_pkg::REM_SRC_UPPER;
          state_next    = S_REM_WAIT;
        end
        S_REM_WAIT: begin
          if (stat.rem_done) begin
            state_next = S_UP;
          end
        end
        S_UP: begin
          cmd.wr_up  = 1'b1;
          state_next = S_HIT;
        end
        S_HIT: begin
          cmd.wr_hit     = 1'b1;
          code_next      = ffra_pkg::ST_OK;
          done_pend_next = 1'b1;
          state_next     = S_IDLE;
        end
        default: begin
          state_next = S_RB_START;
        end
      endcase
    end
    // a register write restarts the rebuild
    if (stat.cfg_write) begin
      state_next     = S_RB_START;
      done_pend_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RB_START;
      done_pend <= 1'b0;
      code      <= ffra_pkg::ST_OK;
    end else begin
      state     <= state_next;
      done_pend <= done_pend_next;
      code      <= code_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ffra_rem.sv
// ----------------------------------------------------------------------------
// ffra_rem
// Page offset of an address: distance up to the next page boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_rem #(
  parameter int PAGE_BYTES = 4096
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [$clog2(PAGE_BYTES)-1:0]    operand,
  output logic                             done,
  output logic [$clog2(PAGE_BYTES)-1:0]    offset
);

  localparam int RW = $clog2(PAGE_BYTES);
  localparam logic [RW:0] PAGE_W = (RW+1)'(PAGE_BYTES);

  logic [RW-1:0] rem;

  // page size is a power of two, so the remainder is the low address bits
  assign offset = (rem == '0) ? '0 : RW'(PAGE_W - {1'b0, rem});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= operand;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Region table, configuration registers, scan and search counters, result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int PAGE_BYTES    = 4096
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  write_enable,
  input  wire  [ffra_pkg::CFG_INDEX_W-1:0] register_index,
  input  wire  [31:0]          write_data,
  input  wire                  in_opcode,
  input  wire  [31:0]          in_length,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [1:0]           out_status,
  output logic [31:0]          out_address,
  input  ffra_pkg::ffra_cmd_t  cmd,
  output ffra_pkg::ffra_stat_t stat
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW = $clog2(PAGE_BYTES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  // configuration
  logic [31:0] region_start, memory_size, rebuild_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= ffra_pkg::RESET_REGION_START;
      memory_size  <= ffra_pkg::RESET_MEMORY_SIZE;
    end else if (write_enable) begin
      unique case (register_index)
        ffra_pkg::REG_REGION_START: region_start <= write_data;
        ffra_pkg::REG_MEMORY_SIZE:  memory_size  <= write_data;
      endcase
    end
  end

  assign rebuild_size = (memory_size != 32'd0 && region_start < memory_size)
                      ? memory_size - 32'd1 - region_start : 32'd0;

  // latched request
  logic        req_aligned;
  logic [31:0] req_len;

  always_ff @(posedge clk) begin
    if (cmd.req_take) begin
      req_aligned <= in_opcode;
      req_len     <= in_length;
    end
  end

  // page remainder unit
  logic          rem_done;
  logic [RW-1:0] rem_off;
  logic [RW-1:0] rem_operand;
  logic [31:0]   hit_addr, hit_size, up_addr;

  assign up_addr     = hit_addr + req_len;
  assign rem_operand = (cmd.rem_src == ffra_pkg::REM_SRC_UPPER) ? up_addr[RW-1:0]
                                                                 : region_start[RW-1:0];

  ffra_rem #(.PAGE_BYTES(PAGE_BYTES)) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.rem_start),
    .operand (rem_operand),
    .done    (rem_done),
    .offset  (rem_off)
  );

  // region table: address, size and stored page offset per entry
  logic [31:0]   ent_addr_mem [TABLE_ENTRIES];
  logic [31:0]   ent_size_mem [TABLE_ENTRIES];
  logic [RW-1:0] ent_off_mem  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ent_valid, ent_used;
  logic [CW-1:0] empty_count;

  logic [IW-1:0] rd_cnt;
  logic [31:0]   rd_addr, rd_size;
  logic [RW-1:0] rd_off;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0]   wr_addr, wr_size;
  logic [RW-1:0] wr_off;

  logic [IW-1:0] hit_idx, k1, k2, k_up;
  logic [RW-1:0] hit_off, hit_soff;
  logic          low_split;

  assign low_split = (hit_off != '0);
  assign k_up      = low_split ? k2 : k1;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = hit_idx;
    wr_addr = hit_addr;
    wr_size = req_len;
    wr_off  = hit_soff;
    if (cmd.wr_rebuild) begin
      wr_en   = 1'b1;
      wr_idx  = '0;
      wr_addr = region_start;
      wr_size = rebuild_size;
      wr_off  = rem_off;
    end else if (cmd.wr_low) begin
      wr_en   = 1'b1;
      wr_idx  = k1;
      wr_size = 32'(hit_off);
    end else if (cmd.wr_up) begin
      wr_en   = 1'b1;
      wr_idx  = k_up;
      wr_addr = up_addr;
      wr_size = hit_size - req_len;
      wr_off  = rem_off;
    end else if (cmd.wr_hit) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_addr_mem[wr_idx] <= wr_addr;
      ent_size_mem[wr_idx] <= wr_size;
      ent_off_mem[wr_idx]  <= wr_off;
    end
    rd_addr <= ent_addr_mem[rd_cnt];
    rd_size <= ent_size_mem[rd_cnt];
    rd_off  <= ent_off_mem[rd_cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid   <= '0;
      ent_used    <= '0;
      empty_count <= '0;
    end else if (cmd.wr_rebuild) begin
      ent_valid   <= TABLE_ENTRIES'(1);
      ent_used    <= '0;
      empty_count <= CW'(TABLE_ENTRIES - 1);
    end else if (cmd.wr_low) begin
      ent_valid[k1] <= 1'b1;
      ent_used[k1]  <= 1'b0;
      empty_count   <= empty_count - CW'(1);
    end else if (cmd.wr_up) begin
      ent_valid[k_up] <= 1'b1;
      ent_used[k_up]  <= 1'b0;
      empty_count     <= empty_count - CW'(1);
    end else if (cmd.wr_hit) begin
      ent_used[hit_idx] <= 1'b1;
    end
  end

  // first-fit scan: read one entry a cycle, test it the cycle after
  logic          ev_vld, ev_free, scan_done, scan_hit, fit;
  logic [IW-1:0] ev_idx;
  logic [RW-1:0] ev_off;
  logic [32:0]   need;

  assign ev_off = req_aligned ? rd_off : '0;
  assign need   = {1'b0, req_len} + 33'(ev_off);
  assign fit    = ev_vld && ev_free && ({1'b0, rd_size} > need);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done <= 1'b0;
      scan_hit  <= 1'b0;
      ev_vld    <= 1'b0;
      rd_cnt    <= '0;
    end else if (cmd.scan_clear) begin
      scan_done <= 1'b0;
      scan_hit  <= 1'b0;
      ev_vld    <= 1'b0;
      rd_cnt    <= '0;
    end else if (cmd.scan_run && !scan_done) begin
      ev_vld <= 1'b1;
      rd_cnt <= rd_cnt + IW'(1);
      if (fit) begin
        scan_hit  <= 1'b1;
        scan_done <= 1'b1;
      end else if (ev_vld && ev_idx == LAST_IDX) begin
        scan_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && !scan_done) begin
      ev_idx  <= rd_cnt;
      ev_free <= ent_valid[rd_cnt] && !ent_used[rd_cnt];
      if (fit) begin
        hit_idx  <= ev_idx;
        hit_addr <= rd_addr;
        hit_size <= rd_size;
        hit_off  <= ev_off;
        hit_soff <= rd_off;
      end
    end else if (cmd.wr_low) begin
      // the granted part now starts on the page boundary
      hit_addr <= hit_addr + 32'(hit_off);
      hit_size <= hit_size - 32'(hit_off);
      hit_soff <= '0;
    end
  end

  // search for one or two empty entries
  logic [IW-1:0] f_cnt;
  logic          f_first, find_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      find_done <= 1'b0;
      f_first   <= 1'b0;
      f_cnt     <= '0;
    end else if (cmd.find_clear) begin
      find_done <= 1'b0;
      f_first   <= 1'b0;
      f_cnt     <= '0;
    end else if (cmd.find_run && !find_done) begin
      f_cnt <= f_cnt + IW'(1);
      if (!ent_valid[f_cnt]) begin
        f_first <= 1'b1;
        if (!f_first && !low_split) begin
          find_done <= 1'b1;
        end else if (f_first) begin
          find_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_run && !find_done && !ent_valid[f_cnt]) begin
      if (!f_first) begin
        k1 <= f_cnt;
      end else begin
        k2 <= f_cnt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      out_status  <= cmd.rsp_code;
      out_address <= (cmd.rsp_code == ffra_pkg::ST_OK) ? hit_addr : 32'd0;
    end
  end

  always_comb begin
    stat           = '0;
    stat.cfg_write = write_enable;
    stat.rem_done  = rem_done;
    stat.scan_done = scan_done;
    stat.scan_hit  = scan_hit;
    stat.need_ok   = empty_count >= (low_split ? CW'(2) : CW'(1));
    stat.find_done = find_done;
    stat.low_split = low_split;
    stat.rsp_free  = !out_valid || out_ready;
  end

  // checks
  a_split_targets_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_low |-> !ent_valid[k1]) and (cmd.wr_up |-> !ent_valid[k_up]))
    else $error("split written over a live entry");

  a_hit_is_free: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_hit |-> ent_valid[hit_idx] && !ent_used[hit_idx])
    else $error("grant on an entry that is not free");

  a_empty_count_range: assert property (@(posedge clk) disable iff (rst)
    empty_count < CW'(TABLE_ENTRIES))
    else $error("empty entry count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |-> !$past(cmd.rsp_load) || !out_valid || out_ready)
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

FILE: tb/tb_first_fit_region_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator
// Self-checking bench for the first-fit region allocator. A behavioral table
// model predicts the status and address of every accepted request. Results
// are matched in order. The run walks through several region settings,
// including empty and full-range memory. Both channels idle at random, and
// the result side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------

module tb_first_fit_region_allocator;

  localparam int          TABLE_ENTRIES = 64;
  localparam logic [31:0] PAGE_BYTES    = 32'd4096;
  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          SETTLE_CYCLES = 150;

  localparam logic OP_PLAIN   = 1'b0;
  localparam logic OP_ALIGNED = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] length;
  } alloc_req_t;

  typedef struct packed {
    ffra_pkg::status_t status;
    logic [31:0]       address;
  } grant_t;

  logic                             clk;
  logic                             rst;
  logic                             write_enable;
  logic [ffra_pkg::CFG_INDEX_W-1:0] register_index;
  logic [31:0]                      write_data;

  ffra_req_if req_ch ();
  ffra_rsp_if rsp_ch ();

  first_fit_region_allocator u_top (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .req            (req_ch),
    .rsp            (rsp_ch)
  );

  // region table model
  logic [31:0] tab_addr  [TABLE_ENTRIES];
  logic [31:0] tab_size  [TABLE_ENTRIES];
  bit          tab_used  [TABLE_ENTRIES];
  bit          tab_valid [TABLE_ENTRIES];
  logic [31:0] cur_start;
  logic [31:0] cur_msize;

  alloc_req_t  pending_reqs[$];
  grant_t      expected_grants[$];

  int          offered_cnt;
  int          accepted_cnt;
  int          results_seen;
  int          mismatches;
  int          cycle_cnt;
  int unsigned req_gap;
  int unsigned rsp_stall;
  int unsigned hold_left;
  int          next_hold_at;
  bit          quiet;

  function automatic void rebuild_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tab_addr[i]  = '0;
      tab_size[i]  = '0;
      tab_used[i]  = 1'b0;
      tab_valid[i] = 1'b0;
    end
    tab_addr[0]  = cur_start;
    tab_size[0]  = (cur_msize != 0 && cur_start < cur_msize) ? cur_msize - 1 - cur_start : '0;
    tab_valid[0] = 1'b1;
  endfunction

  function automatic int first_empty();
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (!tab_valid[i]) return i;
    return TABLE_ENTRIES;
  endfunction

  // first fit with split; updates the table on a grant
  function automatic grant_t allocate(input logic opcode, input logic [31:0] len);
    grant_t      g;
    int          hit;
    int          slot;
    int          empties;
    logic [31:0] off;
    logic [31:0] gap;
    logic [31:0] rem;
    logic [32:0] need;
    hit     = -1;
    off     = '0;
    empties = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!tab_valid[i]) empties++;
      if (hit < 0 && tab_valid[i] && !tab_used[i]) begin
        rem  = tab_addr[i] % PAGE_BYTES;
        gap  = (opcode == OP_ALIGNED && rem != 0) ? PAGE_BYTES - rem : 32'd0;
        need = {1'b0, len} + {1'b0, gap};
        if ({1'b0, tab_size[i]} > need) begin
          hit = i;
          off = gap;
        end
      end
    end
    g.address = '0;
    if (hit < 0) begin
      g.status = ffra_pkg::ST_NO_SPACE;
    end else if (empties < ((off != 0) ? 2 : 1)) begin
      g.status = ffra_pkg::ST_TABLE_FULL;
    end else begin
      if (off != 0) begin
        slot            = first_empty();
        tab_addr[slot]  = tab_addr[hit];
        tab_size[slot]  = off;
        tab_valid[slot] = 1'b1;
        tab_used[slot]  = 1'b0;
        tab_addr[hit]   = tab_addr[hit] + off;
        tab_size[hit]   = tab_size[hit] - off;
      end
      slot            = first_empty();
      tab_addr[slot]  = tab_addr[hit] + len;
      tab_size[slot]  = tab_size[hit] - len;
      tab_valid[slot] = 1'b1;
      tab_used[slot]  = 1'b0;
      tab_size[hit]   = len;
      tab_used[hit]   = 1'b1;
      g.status        = ffra_pkg::ST_OK;
      g.address       = tab_addr[hit];
    end
    return g;
  endfunction

  // mostly short idles, a few long ones
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic alloc_req_t random_req(input logic [31:0] span);
    alloc_req_t  r;
    int unsigned pick;
    r.opcode = $urandom_range(0, 1) ? OP_ALIGNED : OP_PLAIN;
    pick     = $urandom_range(0, 99);
    if (pick < 50)      r.length = $urandom_range(0, 32'h1FFF);
    else if (pick < 70) r.length = $urandom_range(0, 32'hF_FFFF);
    else if (pick < 85) r.length = $urandom_range(0, span);
    else if (pick < 95) r.length = $urandom;
    else                r.length = pick[0] ? 32'hFFFF_FFFF : 32'h0;
    return r;
  endfunction

  task automatic push_req(input logic opcode, input logic [31:0] len);
    alloc_req_t r;
    r.opcode = opcode;
    r.length = len;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ffra_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= value;
    @(negedge clk);
    write_enable   <= 1'b0;
    if (idx == ffra_pkg::REG_REGION_START) cur_start = value;
    else cur_msize = value;
    rebuild_table();
    // table rebuild runs after every write
    repeat (64) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] start, input logic [31:0] msize);
    drain();
    write_reg(ffra_pkg::REG_REGION_START, start);
    write_reg(ffra_pkg::REG_MEMORY_SIZE, msize);
  endtask

  task automatic push_random(input int n);
    logic [31:0] span;
    span = (cur_msize > cur_start) ? cur_msize - cur_start : 32'h1000;
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req(span));
  endtask

  task automatic note_mismatch(input string what);
    if (mismatches < 10) $display("[%0d] %s", cycle_cnt, what);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!(req_ch.valid && offered_cnt != accepted_cnt)) begin
      if (req_gap != 0) begin
        req_gap      <= req_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= pending_reqs[0].opcode;
        req_ch.request_length <= pending_reqs[0].length;
        offered_cnt           <= offered_cnt + 1;
        req_gap               <= idle_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // predict on every accepted request
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_grants.push_back(allocate(req_ch.opcode, req_ch.request_length));
      void'(pending_reqs.pop_front());
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  // result side ready, with a long hold-off now and then to back up the block
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= 3000;
      next_hold_at <= next_hold_at + 400;
    end else if (rsp_stall != 0) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall    <= rsp_stall - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_stall    <= idle_len();
    end
  end

  // result checker
  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_grants.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d address %h",
                                rsp_ch.status, rsp_ch.granted_address));
      end else begin
        want = expected_grants.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.granted_address !== want.address)
          note_mismatch($sformatf("result %0d: expected status %0d address %h, got status %0d address %h",
                                  results_seen, want.status, want.address,
                                  rsp_ch.status, rsp_ch.granted_address));
      end
    end
  end

  initial begin
    logic [31:0] start;
    logic [31:0] msize;
    rst                   = 1'b1;
    write_enable          = 1'b0;
    register_index        = ffra_pkg::REG_REGION_START;
    write_data            = '0;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_PLAIN;
    req_ch.request_length = '0;
    rsp_ch.ready          = 1'b0;
    offered_cnt           = 0;
    accepted_cnt          = 0;
    results_seen          = 0;
    mismatches            = 0;
    req_gap               = 0;
    rsp_stall             = 0;
    hold_left             = 0;
    next_hold_at          = 60;
    quiet                 = 1'b0;
    cur_start             = ffra_pkg::RESET_REGION_START;
    cur_msize             = ffra_pkg::RESET_MEMORY_SIZE;
    rebuild_table();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests on the reset layout
    push_req(OP_PLAIN,   32'h0);            // zero length
    push_req(OP_ALIGNED, 32'h10);           // address already on a page
    push_req(OP_PLAIN,   32'h123);
    push_req(OP_ALIGNED, 32'h1000);         // lower split
    push_req(OP_ALIGNED, 32'h0);
    push_req(OP_PLAIN,   32'h1);
    push_req(OP_ALIGNED, 32'h1);
    push_req(OP_PLAIN,   32'hFFFF_FFFF);    // no fit
    push_req(OP_ALIGNED, 32'hFFFF_FFFF);    // need past 32 bits
    push_req(OP_ALIGNED, 32'hFFFF_F001);
    push_req(OP_PLAIN,   32'h8000_0000);
    push_req(OP_ALIGNED, 32'h7FFF_FFFF);
    push_req(OP_PLAIN,   32'h5555_5555);
    push_req(OP_ALIGNED, 32'hAAAA_AAAA);
    push_req(OP_PLAIN,   32'h00EF_0000);
    push_req(OP_ALIGNED, 32'h0000_0FFF);

    // exact fit is refused, one byte less is granted
    set_config(32'h0000_1000, 32'h0000_2001);
    push_req(OP_PLAIN,   32'h1000);
    push_req(OP_ALIGNED, 32'hFFF);
    push_req(OP_PLAIN,   32'h0);
    push_req(OP_PLAIN,   32'h0);

    // empty memory
    set_config(32'hFFFF_FFFF, 32'h0);
    push_req(OP_PLAIN,   32'h0);
    push_req(OP_ALIGNED, 32'h0);
    set_config(32'h0000_2000, 32'h0000_2000);
    push_req(OP_PLAIN,   32'h0);

    // small unaligned region: fills the table quickly
    set_config(32'h0000_1234, 32'h0002_0000);
    quiet = 1'b1;
    push_random(80);
    set_config(32'h0, 32'hFFFF_FFFF);
    quiet = 1'b0;
    push_random(70);
    set_config(32'hFFFF_E123, 32'hFFFF_FFFF);
    push_random(60);

    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: begin
          start = $urandom_range(0, 32'h00FF_FFFF) & 32'hFFFF_F000;
          msize = start + $urandom_range(1, 32'h0080_0000);
        end
        1: begin
          start = $urandom_range(0, 32'hFFFF);
          msize = start + $urandom_range(0, 32'h3_0000);
        end
        2: begin
          start = $urandom;
          msize = $urandom;
        end
        default: begin
          start = $urandom_range(0, 32'hFFF);
          msize = $urandom;
        end
      endcase
      set_config(start, msize);
      quiet = (p % 3 == 1);
      push_random($urandom_range(50, 90));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: first_fit_region_allocator.f
rtl/ffra_pkg.sv
rtl/ffra_if.sv
rtl/ffra_ctrl.sv
rtl/ffra_rem.sv
rtl/ffra_dp.sv
rtl/first_fit_region_allocator.sv
tb/tb_first_fit_region_allocator.sv
